// ===== hdl/aec_pkg.sv =====
package aec_pkg;

    // Coder geometry
    localparam int CODE_BITS = 16;
    localparam int FREQ_BITS = 14;

    // Field and datapath widths
    localparam int CNT_W    = FREQ_BITS + 1;
    localparam int RANGE_W  = CODE_BITS + 1;
    localparam int PROD_W   = RANGE_W + CNT_W;
    localparam int FOLLOW_W = 32;
    localparam int STEP_W   = $clog2(CODE_BITS + 1);
    localparam int MD_CNT_W = $clog2(PROD_W);

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = FREQ_BITS + CNT_W + CNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + FOLLOW_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Interval thresholds
    localparam logic [CODE_BITS-1:0] HALF  = {1'b1, {(CODE_BITS - 1){1'b0}}};
    localparam logic [CODE_BITS-1:0] QTR   = {2'b01, {(CODE_BITS - 2){1'b0}}};
    localparam logic [CODE_BITS-1:0] THREEQ = {2'b11, {(CODE_BITS - 2){1'b0}}};

    // Request kinds carried in tuser
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_RENORM,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    // Saturating increment of the pending bit count.
    function automatic logic [FOLLOW_W-1:0] sat_inc(input logic [FOLLOW_W-1:0] val);
        logic [FOLLOW_W-1:0] res;
        res = (val == {FOLLOW_W{1'b1}}) ? val : val + FOLLOW_W'(1);
        return res;
    endfunction

endpackage

// ===== hdl/aec_muldiv.sv =====
module aec_muldiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [aec_pkg::RANGE_W-1:0] range_in,
    input  logic [aec_pkg::CNT_W-1:0]   count_in,
    input  logic [aec_pkg::CNT_W-1:0]   total_in,
    output logic                        done,
    output logic [aec_pkg::RANGE_W-1:0] quot
);
    import aec_pkg::*;

    md_phase_t             phase_reg, phase_next;
    logic [MD_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]     mcand_reg, mcand_next;
    logic [CNT_W-1:0]      mplier_reg, mplier_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      div_reg, div_next;
    logic                  done_reg, done_next;
    logic [CNT_W:0]        trial;
    logic                  qbit;

    // Restoring division step: bring down the next dividend bit.
    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
    end

    // Shift-and-add multiply one multiplier bit a cycle, then divide one
    // quotient bit a cycle, reusing the product register for the quotient.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        done_next   = 1'b0;
        unique case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    mcand_next  = PROD_W'(range_in);
                    mplier_next = count_in;
                    div_next    = total_in;
                    prod_next   = '0;
                    cnt_next    = MD_CNT_W'(CNT_W - 1);
                    phase_next  = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[CNT_W-1:1]};
                cnt_next    = cnt_reg - MD_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = MD_CNT_W'(PROD_W - 1);
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next  = qbit ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], qbit};
                cnt_next  = cnt_reg - MD_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = MD_IDLE;
                end
            end
            default:
            begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = prod_reg[RANGE_W-1:0];

endmodule

// ===== hdl/arithmetic_encoder_core.sv =====
// Flush request: one result, loaded from the flush state once the output is free.
// Symbol request: a serial multiply and a serial restoring division, then at most 16
// renormalisation steps; a step that must release a held bit waits while the output is
// stalled. Each emitted bit is held back one step so the final one carries tlast.
// One request is processed at a time; the output register lets a result wait.
// rst_n asynchronously resets the interval to its full width and clears the pending count.
module arithmetic_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cum_low, cum_high, total, zero padding
    input  logic [aec_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bit_res, follow_count, zero padding
    output logic [aec_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import aec_pkg::*;

    state_t                state_reg, state_next;
    logic [CODE_BITS-1:0]  low_reg, low_next;
    logic [CODE_BITS-1:0]  high_reg, high_next;
    logic [FOLLOW_W-1:0]   pend_reg, pend_next;
    logic                  fin_reg, fin_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_bit_reg, held_bit_next;
    logic [FOLLOW_W-1:0]   held_follow_reg, held_follow_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_bit_reg, out_bit_next;
    logic [FOLLOW_W-1:0]   out_follow_reg, out_follow_next;
    logic                  out_last_reg, out_last_next;

    logic [FREQ_BITS-1:0]  in_clo;
    logic [CNT_W-1:0]      in_chi;
    logic [CNT_W-1:0]      in_tot;
    logic                  counts_ok;
    logic [RANGE_W-1:0]    range;
    logic                  md_start;
    logic                  hi_done;
    logic                  lo_done;
    logic [RANGE_W-1:0]    hi_off;
    logic [RANGE_W-1:0]    lo_off;
    logic                  out_free;
    logic                  emit0;
    logic                  emit1;
    logic                  quart;
    logic                  stop;
    logic [CODE_BITS-1:0]  low_adj;
    logic [CODE_BITS-1:0]  high_adj;

    // Request fields
    assign in_clo = s_tdata[FREQ_BITS-1:0];
    assign in_chi = s_tdata[FREQ_BITS+CNT_W-1:FREQ_BITS];
    assign in_tot = s_tdata[S_FIELDS_W-1:FREQ_BITS+CNT_W];

    assign counts_ok = (in_tot != '0) && ({1'b0, in_clo} < in_chi) && (in_chi <= in_tot);
    assign range     = {1'b0, high_reg} - {1'b0, low_reg} + RANGE_W'(1);

    // Serial units for range*cum_high/total and range*cum_low/total
    aec_muldiv u_hi_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .range_in (range),
        .count_in (in_chi),
        .total_in (in_tot),
        .done     (hi_done),
        .quot     (hi_off)
    );

    aec_muldiv u_lo_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .range_in (range),
        .count_in (CNT_W'(in_clo)),
        .total_in (in_tot),
        .done     (lo_done),
        .quot     (lo_off)
    );

    // Renormalisation step decode
    assign out_free = !m_valid_reg || m_tready;
    assign emit0    = (high_reg < HALF);
    assign emit1    = !emit0 && (low_reg >= HALF);
    assign quart    = !emit0 && !emit1 && (low_reg >= QTR) && (high_reg < THREEQ);
    assign stop     = (step_reg == STEP_W'(CODE_BITS)) || !(emit0 || emit1 || quart);
    assign low_adj  = emit1 ? (low_reg - HALF) : (quart ? (low_reg - QTR) : low_reg);
    assign high_adj = emit1 ? (high_reg - HALF) : (quart ? (high_reg - QTR) : high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            high_reg       <= '1;
            pend_reg       <= '0;
            fin_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_reg       <= pend_next;
            fin_reg        <= fin_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        held_bit_reg    <= held_bit_next;
        held_follow_reg <= held_follow_next;
        out_bit_reg     <= out_bit_next;
        out_follow_reg  <= out_follow_next;
        out_last_reg    <= out_last_next;
    end

    // Sequencer: accept, wait for the serial units, renormalise, flush
    always_comb
    begin
        state_next       = state_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        pend_next        = pend_reg;
        fin_next         = fin_reg;
        step_next        = step_reg;
        held_valid_next  = held_valid_reg;
        held_bit_next    = held_bit_reg;
        held_follow_next = held_follow_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_bit_next     = out_bit_reg;
        out_follow_next  = out_follow_reg;
        out_last_next    = out_last_reg;
        md_start         = 1'b0;
        s_tready         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && !fin_reg)
                begin
                    if (s_tuser[0] == KIND_FLUSH)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (counts_ok)
                    begin
                        md_start   = 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (hi_done && lo_done)
                begin
                    if (hi_off > lo_off)
                    begin
                        high_next       = CODE_BITS'({1'b0, low_reg} + hi_off - RANGE_W'(1));
                        low_next        = CODE_BITS'({1'b0, low_reg} + lo_off);
                        step_next       = '0;
                        held_valid_next = 1'b0;
                        state_next      = ST_RENORM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RENORM:
            begin
                priority if (stop)
                begin
                    // Release the held bit as the final result of this symbol.
                    if (!held_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        m_valid_next    = 1'b1;
                        out_bit_next    = held_bit_reg;
                        out_follow_next = held_follow_reg;
                        out_last_next   = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (emit0 || emit1)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            m_valid_next    = 1'b1;
                            out_bit_next    = held_bit_reg;
                            out_follow_next = held_follow_reg;
                            out_last_next   = 1'b0;
                        end
                        held_valid_next  = 1'b1;
                        held_bit_next    = emit1;
                        held_follow_next = pend_reg;
                        pend_next        = '0;
                        low_next         = {low_adj[CODE_BITS-2:0], 1'b0};
                        high_next        = {high_adj[CODE_BITS-2:0], 1'b1};
                        step_next        = step_reg + STEP_W'(1);
                    end
                end
                else
                begin
                    // Middle-half expansion: one more pending bit.
                    pend_next = sat_inc(pend_reg);
                    low_next  = {low_adj[CODE_BITS-2:0], 1'b0};
                    high_next = {high_adj[CODE_BITS-2:0], 1'b1};
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_bit_next    = (low_reg >= QTR);
                    out_follow_next = sat_inc(pend_reg);
                    out_last_next   = 1'b1;
                    pend_next       = '0;
                    fin_next        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_follow_reg, out_bit_reg});
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/aec_checker.sv =====
module aec_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [aec_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [aec_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast
);
    import aec_pkg::*;

    logic fin_reg;
    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // Tracks whether a flush request has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
        end
        else if (s_acc && (s_tuser[0] == KIND_FLUSH))
        begin
            fin_reg <= 1'b1;
        end
    end

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The first flush keeps the core busy while its result is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser[0] == KIND_FLUSH) && !fin_reg |=> !s_tready)
        else $error("core ready straight after a flush request");

    // Leaving reset the core is idle with no result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> s_tready && !m_tvalid)
        else $error("core not idle after reset");

    // An accepted symbol request never carries unknown counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> !$isunknown(s_tdata[S_FIELDS_W-1:0]) || (s_tuser[0] == KIND_FLUSH))
        else $error("symbol request with unknown counts");

endmodule

bind arithmetic_encoder_core aec_checker u_aec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
